// ----- hw/rtl/dsplit_pkg.sv -----
// Shared types and constants for the delimiter string splitter.
package dsplit_pkg;

  localparam int WIN_BYTES  = 8;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [1:0] CFG_DELIM_BYTES  = 2'd0;
  localparam logic [1:0] CFG_DELIM_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BASE_OFFSET  = 2'd2;

  typedef struct packed {
    logic [WIN_BYTES-1:0][7:0] bytes;
    logic [3:0]                len;
  } delim_cfg_t;

  typedef struct packed {
    logic [15:0] seg_start;
    logic [15:0] seg_end;
    logic        last_segment;
    logic        too_long;
  } seg_t;

endpackage

// ----- hw/rtl/dsplit_cell.sv -----
// One window cell: holds a byte, passes it on, compares the arriving byte.
module dsplit_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  logic                clear,
  input  logic [7:0]          byte_in,
  input  dsplit_pkg::delim_cfg_t dcfg,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import dsplit_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       in_use;
  logic [3:0] jdx;

  assign in_use = 4'(IDX) < dcfg.len;
  assign jdx    = 4'(dcfg.len - 4'd1 - 4'(IDX));
  assign hit    = !in_use || (byte_in == dcfg.bytes[jdx[2:0]]);
  assign byte_out = byte_r;

  always_comb begin
    byte_nxt = byte_r;
    if (clear) begin
      byte_nxt = 8'd0;
    end else if (shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ----- hw/rtl/dsplit_outq.sv -----
// Result queue: takes up to two segments per cycle, hands out one.
module dsplit_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_a,
  input  logic                push_b,
  input  dsplit_pkg::seg_t    data_a,
  input  dsplit_pkg::seg_t    data_b,
  input  logic                pop,
  output logic                not_empty,
  output logic                nearly_full,
  output dsplit_pkg::seg_t    head
);
  import dsplit_pkg::*;

  seg_t                 mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_AW:0]     count_r, count_nxt;
  logic [OUTQ_AW-1:0]   wr_ptr_b;
  logic [OUTQ_AW:0]     n_push;

  assign not_empty   = count_r != '0;
  assign nearly_full = count_r > (OUTQ_AW+1)'(OUTQ_DEPTH - 2);
  assign head        = mem_r[rd_ptr_r];
  assign wr_ptr_b    = wr_ptr_r + (OUTQ_AW)'(push_a);
  assign n_push      = (OUTQ_AW+1)'(push_a) + (OUTQ_AW+1)'(push_b);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[OUTQ_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + (OUTQ_AW)'(pop);
    count_nxt  = count_r + n_push - (OUTQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      mem_r[wr_ptr_b] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/delimiter_string_splitter.sv -----
// Top level of the delimiter string splitter.
// Takes one byte per cycle; a row of byte cells forms the match window and
// compares every byte of the delimiter in parallel, so a match is known in
// the cycle its last byte arrives. Each item yields zero, one or two
// segments into a four-entry result queue; the input stalls while the queue
// holds more than two segments, so a sustained rate of one item per cycle
// holds whenever results are taken as fast as they appear. Segment start
// and end are base_offset plus the byte count, saturating at
// min(MAX_LEN, 65535), with too_long set from the byte that passed it until
// the end of the string.
module delimiter_string_splitter #(
  parameter int              MAX_DELIM = 8,
  parameter longint unsigned MAX_LEN   = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_seg_start,
  output logic [15:0] out_seg_end,
  output logic        out_last_segment,
  output logic        out_too_long,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import dsplit_pkg::*;

  localparam int NCELL = (MAX_DELIM < WIN_BYTES) ? MAX_DELIM : WIN_BYTES;
  localparam logic [3:0] LEN_CAP = 4'(NCELL);
  localparam logic [17:0] LIMIT = (MAX_LEN > 65535) ? 18'd65535 : 18'(MAX_LEN);

  logic [63:0] delim_bytes_r;
  logic [3:0]  delim_len_r;
  logic [15:0] base_r;
  logic [16:0] cnt_r, cnt_nxt;
  logic [15:0] begin_r, begin_nxt;
  logic [3:0]  since_r, since_nxt;
  logic        ovf_r, ovf_nxt;

  delim_cfg_t  dcfg;
  logic        accept, shift, clear;
  logic [7:0]  cell_in  [NCELL];
  logic [7:0]  cell_out [NCELL];
  logic [NCELL-1:0] cell_hit;
  logic [16:0] cnt_inc, cnt_new, mstart;
  logic [15:0] begin_new;
  logic [3:0]  since_inc;
  logic        ovf_new, match;
  seg_t        seg_mid, seg_fin, data_a, head;
  logic        push_a, push_b, q_full, q_ne;

  function automatic logic [15:0] abs_pos(input logic [15:0] b, input logic [16:0] rel);
    logic [17:0] s;
    s = {2'b00, b} + {1'b0, rel};
    return (s > LIMIT) ? LIMIT[15:0] : s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= 64'd44;
      delim_len_r   <= 4'd1;
      base_r        <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIM_BYTES:  delim_bytes_r <= cfg_wdata;
        CFG_DELIM_LENGTH: delim_len_r   <= cfg_wdata[3:0];
        CFG_BASE_OFFSET:  base_r        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign dcfg.bytes = delim_bytes_r;
  assign dcfg.len   = (delim_len_r > LEN_CAP) ? LEN_CAP : delim_len_r;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign shift    = accept && in_byte_valid;
  assign clear    = accept && in_end_of_string;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_char_byte;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    dsplit_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .clear    (clear),
      .byte_in  (cell_in[k]),
      .dcfg     (dcfg),
      .byte_out (cell_out[k]),
      .hit      (cell_hit[k])
    );
  end

  always_comb begin
    cnt_inc   = (cnt_r != '1) ? cnt_r + 17'd1 : cnt_r;
    cnt_new   = in_byte_valid ? cnt_inc : cnt_r;
    since_inc = (since_r != 4'hF) ? since_r + 4'd1 : since_r;
    ovf_new   = ovf_r ||
                (in_byte_valid && (({2'b00, base_r} + {1'b0, cnt_inc}) > LIMIT));
    match     = in_byte_valid && (dcfg.len != 4'd0) &&
                (({1'b0, since_r} + 5'd1) >= {1'b0, dcfg.len}) && (&cell_hit);
    mstart    = cnt_inc - {13'd0, dcfg.len};
    begin_new = match ? ((cnt_inc > 17'hFFFF) ? 16'hFFFF : cnt_inc[15:0]) : begin_r;

    seg_mid.seg_start    = abs_pos(base_r, {1'b0, begin_r});
    seg_mid.seg_end      = abs_pos(base_r, mstart);
    seg_mid.last_segment = 1'b0;
    seg_mid.too_long     = ovf_new;
    seg_fin.seg_start    = abs_pos(base_r, {1'b0, begin_new});
    seg_fin.seg_end      = abs_pos(base_r, cnt_new);
    seg_fin.last_segment = 1'b1;
    seg_fin.too_long     = ovf_new;

    push_a = accept && (match || in_end_of_string);
    push_b = accept && match && in_end_of_string;
    data_a = match ? seg_mid : seg_fin;
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    begin_nxt = begin_r;
    since_nxt = since_r;
    ovf_nxt   = ovf_r;
    if (clear) begin
      cnt_nxt   = '0;
      begin_nxt = '0;
      since_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (shift) begin
      cnt_nxt   = cnt_new;
      begin_nxt = begin_new;
      since_nxt = match ? 4'd0 : since_inc;
      ovf_nxt   = ovf_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      begin_r <= '0;
      since_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      begin_r <= begin_nxt;
      since_r <= since_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  dsplit_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_a      (push_a),
    .push_b      (push_b),
    .data_a      (data_a),
    .data_b      (seg_fin),
    .pop         (q_ne && !out_stall),
    .not_empty   (q_ne),
    .nearly_full (q_full),
    .head        (head)
  );

  assign out_valid        = q_ne;
  assign out_seg_start    = head.seg_start;
  assign out_seg_end      = head.seg_end;
  assign out_last_segment = head.last_segment;
  assign out_too_long     = head.too_long;

endmodule

// ----- hw/rtl/dsplit_checker.sv -----
// Port-level checks for the delimiter string splitter, bound to the top.
module dsplit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_seg_start,
  input logic [15:0] out_seg_end,
  input logic        out_last_segment,
  input logic        out_too_long
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seg_start) &&
      $stable(out_seg_end) && $stable(out_last_segment) && $stable(out_too_long))
    else $error("stalled result changed");

  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seg_start <= out_seg_end)
    else $error("segment ends before it starts");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind delimiter_string_splitter dsplit_checker u_dsplit_checker (.*);

// ----- dv/delimiter_string_splitter_tb.sv -----
// Testbench for the delimiter string splitter: directed table, random strings, predictor check.
module delimiter_string_splitter_tb;
  import dsplit_pkg::*;

  localparam logic [7:0] COMMA = 8'h2C;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CALM_ITEMS = 1500;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_seg_start;
  logic [15:0] out_seg_end;
  logic        out_last_segment;
  logic        out_too_long;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DELIM_BYTES;
  logic [63:0] cfg_wdata = '0;

  delimiter_string_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_start    (out_seg_start),
    .out_seg_end      (out_seg_end),
    .out_last_segment (out_last_segment),
    .out_too_long     (out_too_long),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  typedef struct {
    logic        is_cfg;
    logic [63:0] dbytes;
    logic [3:0]  dlen;
    logic [15:0] dbase;
    logic [7:0]  b;
    logic        bv;
    logic        eos;
    logic        typed;
    seg_t        want;
  } plan_row_t;

  plan_row_t plan[$];

  // split state and register copies
  logic [63:0] win_q = '0;
  logic [16:0] count_q = '0;
  logic [15:0] open_q = '0;
  logic [3:0]  since_q = '0;
  logic        ovf_q = 1'b0;
  logic [63:0] m_delim = 64'd44;
  logic [3:0]  m_len = 4'd1;
  logic [15:0] m_base = 16'd0;

  seg_t        segs_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned taken = 0;
  int unsigned idle_pct = 20;
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [15:0] place(input logic [16:0] rel);
    logic [17:0] v;
    v = {2'b00, m_base} + {1'b0, rel};
    return (v > 18'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int split_step(input logic [7:0] b, input logic bv, input logic eos);
    int unsigned len;
    int unsigned prior;
    logic        hit;
    seg_t        s;
    int          n;
    n = 0;
    if (bv) begin
      len = (m_len > 4'd8) ? 8 : m_len;
      prior = since_q;
      win_q = {win_q[55:0], b};
      if (count_q != 17'h1FFFF) count_q++;
      if ({2'b00, m_base} + {1'b0, count_q} > 18'd65535) ovf_q = 1'b1;
      since_q = 4'((prior < 15) ? prior + 1 : 15);
      hit = (len > 0) && (prior + 1 >= len);
      for (int j = 0; j < len; j++) begin
        if (win_q[8*(len-1-j) +: 8] != m_delim[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        s.seg_start = place({1'b0, open_q});
        s.seg_end = place(17'(count_q - len));
        s.last_segment = 1'b0;
        s.too_long = ovf_q;
        segs_due.push_back(s);
        n++;
        open_q = (count_q > 17'h0FFFF) ? 16'hFFFF : count_q[15:0];
        since_q = '0;
      end
    end
    if (eos) begin
      s.seg_start = place({1'b0, open_q});
      s.seg_end = place(count_q);
      s.last_segment = 1'b1;
      s.too_long = ovf_q;
      segs_due.push_back(s);
      n++;
      win_q = '0;
      count_q = '0;
      open_q = '0;
      since_q = '0;
      ovf_q = 1'b0;
    end
    return n;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic bv, input logic eos,
                           output int n);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= b;
    in_byte_valid <= bv;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    n = split_step(b, bv, eos);
    if (bv || eos) taken++;
  endtask

  task automatic program_regs(input logic [63:0] bytes_v, input logic [3:0] len_v,
                              input logic [15:0] base_v);
    in_valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELIM_BYTES;
    cfg_wdata <= bytes_v;
    @(posedge clk);
    cfg_index <= CFG_DELIM_LENGTH;
    cfg_wdata <= {60'd0, len_v};
    @(posedge clk);
    cfg_index <= CFG_BASE_OFFSET;
    cfg_wdata <= {48'd0, base_v};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_delim = bytes_v;
    m_len = len_v;
    m_base = base_v;
  endtask

  function automatic void add_row(input logic is_cfg, input logic [63:0] dbytes,
                                  input logic [3:0] dlen, input logic [15:0] dbase,
                                  input logic [7:0] b, input logic bv, input logic eos,
                                  input logic typed, input logic [15:0] ws,
                                  input logic [15:0] we, input logic wl, input logic wt);
    plan_row_t r;
    r.is_cfg = is_cfg;
    r.dbytes = dbytes;
    r.dlen = dlen;
    r.dbase = dbase;
    r.b = b;
    r.bv = bv;
    r.eos = eos;
    r.typed = typed;
    r.want.seg_start = ws;
    r.want.seg_end = we;
    r.want.last_segment = wl;
    r.want.too_long = wt;
    plan.push_back(r);
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic bv, input logic eos);
    add_row(1'b0, '0, '0, '0, b, bv, eos, 1'b0, '0, '0, 1'b0, 1'b0);
  endfunction

  function automatic void add_cfg(input logic [63:0] dbytes, input logic [3:0] dlen,
                                  input logic [15:0] dbase);
    add_row(1'b1, dbytes, dlen, dbase, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
  endfunction

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    seg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (segs_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected segment: start %0d end %0d last %0d too_long %0d",
                   out_seg_start, out_seg_end, out_last_segment, out_too_long);
      end else begin
        want = segs_due.pop_front();
        if (out_seg_start !== want.seg_start || out_seg_end !== want.seg_end ||
            out_last_segment !== want.last_segment || out_too_long !== want.too_long) begin
          errors++;
          if (errors <= 10)
            $display("segment mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.seg_start, want.seg_end, want.last_segment, want.too_long,
                     out_seg_start, out_seg_end, out_last_segment, out_too_long);
        end
      end
    end
  end

  initial begin : stim
    logic [7:0]  text[$];
    logic [63:0] rb;
    logic [3:0]  rl;
    logic [15:0] ro;
    int          n;
    int          el;
    int          kind;
    int          slen;
    int          n_str;
    int          pick;

    // after reset: empty string
    add_row(1'b0, '0, '0, '0, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0);
    add_item("a", 1'b1, 1'b0);
    add_item(COMMA, 1'b1, 1'b0);
    add_item(COMMA, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item("b", 1'b1, 1'b1);
    add_item(COMMA, 1'b1, 1'b1);
    // splitting disabled
    add_cfg(64'd44, 4'd0, 16'd0);
    add_item(COMMA, 1'b1, 1'b0);
    add_row(1'b0, '0, '0, '0, 8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd2, 1'b1, 1'b0);
    // oversized length clamps to eight bytes
    add_cfg({64{1'b1}}, 4'd15, 16'd0);
    for (int i = 0; i < 7; i++) add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1);
    // position overflow
    add_cfg(64'd44, 4'd1, 16'd65534);
    add_item("x", 1'b1, 1'b0);
    add_row(1'b0, '0, '0, '0, COMMA, 1'b1, 1'b0, 1'b1, 16'd65534, 16'd65535, 1'b0, 1'b1);
    add_row(1'b0, '0, '0, '0, "z", 1'b1, 1'b1, 1'b1, 16'd65535, 16'd65535, 1'b1, 1'b1);
    // offset change in the middle of a string
    add_cfg(64'd44, 4'd1, 16'd0);
    add_item("a", 1'b1, 1'b0);
    add_cfg(64'd44, 4'd1, 16'd100);
    add_item(COMMA, 1'b1, 1'b1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        program_regs(plan[i].dbytes, plan[i].dlen, plan[i].dbase);
      end else begin
        send_item(plan[i].b, plan[i].bv, plan[i].eos, n);
        if (plan[i].typed) segs_due[segs_due.size() - n] = plan[i].want;
      end
    end

    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      rl = 4'((pick < 6) ? $urandom_range(1, 3) : $urandom_range(0, 15));
      rb = {$urandom, $urandom};
      pick = $urandom_range(0, 5);
      case (pick)
        0: ro = 16'd0;
        1: ro = 16'hFFFF;
        2: ro = 16'(16'hFFFF - $urandom_range(0, 30));
        default: ro = 16'($urandom_range(0, 65535));
      endcase
      pick = $urandom_range(0, 3);
      idle_pct = (pick == 0) ? 0 : pick * 12;
      program_regs(rb, rl, ro);
      el = (m_len > 4'd8) ? 8 : m_len;
      n_str = $urandom_range(3, 8);
      for (int s = 0; s < n_str; s++) begin
        calm = (taken > CALM_ITEMS);
        kind = $urandom_range(0, 9);
        text.delete();
        if (kind == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, n);
        end else if (kind == 1) begin
          slen = $urandom_range(1, 16);
          for (int i = 0; i < slen; i++)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      i == slen - 1, n);
        end else begin
          slen = $urandom_range(0, 24);
          while (text.size() < slen) begin
            if (el > 0 && $urandom_range(0, 3) == 0) begin
              for (int j = 0; j < el; j++) text.push_back(m_delim[8*j +: 8]);
            end else if (el > 0 && $urandom_range(0, 2) != 0) begin
              text.push_back(m_delim[8*$urandom_range(0, el - 1) +: 8]);
            end else begin
              text.push_back(8'($urandom_range(0, 255)));
            end
          end
          if (text.size() == 0 || $urandom_range(0, 4) == 0) begin
            foreach (text[i]) send_item(text[i], 1'b1, 1'b0, n);
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, n);
          end else begin
            foreach (text[i]) send_item(text[i], 1'b1, i == text.size() - 1, n);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
